@@ design/tafr_pkg.sv @@
package tafr_pkg;

	localparam int TILES      = 256;
	localparam int MAX_FRAMES = 16;
	localparam int US_PER_MS  = 1000;

	localparam int TILE_W    = (TILES > 1) ? $clog2(TILES) : 1;
	localparam int SLOT_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
	localparam int ADDR_W    = (TILES * MAX_FRAMES > 1) ? $clog2(TILES * MAX_FRAMES) : 1;
	localparam int TOT_W     = 32 + $clog2(MAX_FRAMES);
	localparam int REM_W     = TOT_W + 1;
	localparam int DIV_STEPS = 64;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

	localparam int MS_DIG_W  = 16;
	localparam int MS_DIGITS = 64 / MS_DIG_W;
	localparam int MCNT_W    = $clog2(MS_DIGITS + 1);
	localparam int MSR_W     = $clog2(US_PER_MS);
	localparam int MSP_W     = MSR_W + MS_DIG_W;
	localparam int MS_SHIFT  = MSP_W + MSR_W;
	localparam int RCP_W     = MS_SHIFT - MSR_W + 1;
	localparam int MSM_W     = MSP_W + RCP_W;
	localparam logic [RCP_W-1:0] MS_RECIP =
		RCP_W'(((64'd1 << MS_SHIFT) + 64'(US_PER_MS - 1)) / 64'(US_PER_MS));

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_RESOLVE = 2'd2,
		ACT_CLEAR   = 2'd3
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [31:0]        tile_id;
		logic [3:0]         frame_slot;
		logic [31:0]        frame_tile;
		logic [31:0]        duration_ms;
		logic               last_frame;
		logic signed [63:0] now_us;
	} in_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]  cnt;
		logic [SLOT_W-1:0] cur;
		logic [31:0]       el;
	} tile_state_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_CLEAR,
		CMD_START_TIME,
		CMD_DIFF,
		CMD_DMS_LATCH,
		CMD_STORE_WR,
		CMD_TSTATE_RD_IN,
		CMD_TSTATE_RD_T,
		CMD_TILE_LOAD,
		CMD_DUR_RD,
		CMD_WALK_STEP,
		CMD_MOD_START,
		CMD_MOD_DONE,
		CMD_TSTATE_WB,
		CMD_TILE_NEXT,
		CMD_RES_RD,
		CMD_EMIT_LOAD,
		CMD_EMIT_SELF,
		CMD_EMIT_STORE
	} dp_cmd_t;

	typedef struct packed {
		action_t act;
		logic    load_bad;
		logic    started;
		logic    div_busy;
		logic    div_q_zero;
		logic    tile_n_zero;
		logic    walk_stop;
		logic    walk_full;
		logic    pass;
		logic    last_tile;
		logic    res_hit;
		logic    out_free;
	} dp_stat_t;

endpackage

@@ design/tafr_if.sv @@
interface tafr_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [31:0]        tile_id;
	logic [3:0]         frame_slot;
	logic [31:0]        frame_tile;
	logic [31:0]        duration_ms;
	logic               last_frame;
	logic signed [63:0] now_us;

	modport source (output valid, action, tile_id, frame_slot, frame_tile, duration_ms,
		last_frame, now_us, input ready);
	modport sink (input valid, action, tile_id, frame_slot, frame_tile, duration_ms,
		last_frame, now_us, output ready);
endinterface

interface tafr_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [31:0] resolved_tile;

	modport source (output valid, status, resolved_tile, input ready);
	modport sink (input valid, status, resolved_tile, output ready);
endinterface

@@ design/tafr_ctrl.sv @@
module tafr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  tafr_pkg::dp_stat_t stat,
	output tafr_pkg::dp_cmd_t  cmd
);
	import tafr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_EMIT_LD, S_RES_CHK, S_RES_ST, S_RES_SELF, S_DIV_WAIT,
		S_T_RD, S_T_LOAD, S_W_RD, S_W_CHK, S_MOD_GO, S_MOD_WAIT, S_WB, S_T_NEXT
	} state_t;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd      = CMD_CAPTURE;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.act)
					ACT_LOAD: begin
						if (!stat.load_bad) cmd = CMD_STORE_WR;
						state_nx = S_EMIT_LD;
					end
					ACT_TICK: begin
						if (!stat.started) begin
							cmd      = CMD_START_TIME;
							state_nx = S_IDLE;
						end else begin
							cmd      = CMD_DIFF;
							state_nx = S_DIV_WAIT;
						end
					end
					ACT_RESOLVE: begin
						cmd      = CMD_TSTATE_RD_IN;
						state_nx = S_RES_CHK;
					end
					ACT_CLEAR: begin
						cmd      = CMD_CLEAR;
						state_nx = S_IDLE;
					end
					default: state_nx = S_IDLE;
				endcase
			end
			S_EMIT_LD: begin
				if (stat.out_free) begin
					cmd      = CMD_EMIT_LOAD;
					state_nx = S_IDLE;
				end
			end
			S_RES_CHK: begin
				if (stat.res_hit) begin
					cmd      = CMD_RES_RD;
					state_nx = S_RES_ST;
				end else begin
					state_nx = S_RES_SELF;
				end
			end
			S_RES_ST: begin
				if (stat.out_free) begin
					cmd      = CMD_EMIT_STORE;
					state_nx = S_IDLE;
				end
			end
			S_RES_SELF: begin
				if (stat.out_free) begin
					cmd      = CMD_EMIT_SELF;
					state_nx = S_IDLE;
				end
			end
			S_DIV_WAIT: begin
				if (!stat.div_busy) begin
					cmd      = CMD_DMS_LATCH;
					state_nx = stat.div_q_zero ? S_IDLE : S_T_RD;
				end
			end
			S_T_RD: begin
				cmd      = CMD_TSTATE_RD_T;
				state_nx = S_T_LOAD;
			end
			S_T_LOAD: begin
				if (stat.tile_n_zero) begin
					state_nx = S_T_NEXT;
				end else begin
					cmd      = CMD_TILE_LOAD;
					state_nx = S_W_RD;
				end
			end
			S_W_RD: begin
				cmd      = CMD_DUR_RD;
				state_nx = S_W_CHK;
			end
			S_W_CHK: begin
				if (stat.walk_stop) begin
					state_nx = S_WB;
				end else begin
					cmd = CMD_WALK_STEP;
					if (!stat.walk_full) state_nx = S_W_RD;
					else if (!stat.pass) state_nx = S_MOD_GO;
					else state_nx = S_WB;
				end
			end
			S_MOD_GO: begin
				cmd      = CMD_MOD_START;
				state_nx = S_MOD_WAIT;
			end
			S_MOD_WAIT: begin
				if (!stat.div_busy) begin
					cmd      = CMD_MOD_DONE;
					state_nx = S_W_RD;
				end
			end
			S_WB: begin
				cmd      = CMD_TSTATE_WB;
				state_nx = S_T_NEXT;
			end
			S_T_NEXT: begin
				if (stat.last_tile) begin
					state_nx = S_IDLE;
				end else begin
					cmd      = CMD_TILE_NEXT;
					state_nx = S_T_RD;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule

@@ design/tafr_datapath.sv @@
module tafr_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  tafr_pkg::in_word_t in_word,
	input  tafr_pkg::dp_cmd_t  cmd,
	output tafr_pkg::dp_stat_t stat,
	tafr_out_if.source         rsp
);
	import tafr_pkg::*;

	in_word_t          in_q;
	logic              started_q;
	logic [63:0]       last_us_q;
	logic [63:0]       dvd_q;
	logic [REM_W-1:0]  rem_q;
	logic [TOT_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [63:0]       msd_q;
	logic [MSR_W-1:0]  msr_q;
	logic [31:0]       msq_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [31:0]       dms_q;
	logic [TILE_W-1:0] t_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  steps_q;
	logic [SLOT_W-1:0] cur_q;
	logic [31:0]       el_q;
	logic [TOT_W-1:0]  total_q;
	logic              pass_q;

	tile_state_t       tst_mem [TILES];
	logic [TILES-1:0]  tv_q;
	tile_state_t       tst_rd_q;
	logic              tv_rd_q;
	tile_state_t       tst;

	logic [63:0]       st_mem [TILES*MAX_FRAMES];
	logic [63:0]       st_rd_q;

	logic              out_valid_q;
	logic              out_status_q;
	logic [31:0]       out_tile_q;

	logic [TILE_W-1:0] in_tile;
	logic              in_range;
	logic              load_bad;
	logic [31:0]       dur;
	logic [63:0]       diff;
	logic [REM_W-1:0]  rem_sh;
	logic              ge;
	logic [MSP_W-1:0]  ms_p;
	logic [MSM_W-1:0]  ms_prod;
	logic [MS_DIG_W-1:0] ms_qd;
	logic [MSP_W-1:0]  ms_rd;
	logic [TILE_W-1:0] tst_ra;
	logic              tst_re;
	logic              tst_we;
	logic [TILE_W-1:0] tst_wa;
	tile_state_t       tst_wd;
	logic [ADDR_W-1:0] st_ra;
	logic [ADDR_W-1:0] st_wa;
	logic [SLOT_W-1:0] cur_nx;
	logic              out_free;

	function automatic logic [ADDR_W-1:0] st_addr(logic [TILE_W-1:0] t, logic [SLOT_W-1:0] s);
		return ADDR_W'(t) * ADDR_W'(MAX_FRAMES) + ADDR_W'(s);
	endfunction

	assign in_tile  = TILE_W'(in_q.tile_id);
	assign in_range = in_q.tile_id < 32'(TILES);
	assign load_bad = !in_range || ({28'd0, in_q.frame_slot} >= 32'(MAX_FRAMES));
	assign tst      = tv_rd_q ? tst_rd_q : '0;
	assign dur      = st_rd_q[31:0];
	assign diff     = in_q.now_us - last_us_q;
	assign rem_sh   = {rem_q[REM_W-2:0], dvd_q[63]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign out_free = !out_valid_q || rsp.ready;

	assign ms_p    = {msr_q, msd_q[63 -: MS_DIG_W]};
	assign ms_prod = MSM_W'(ms_p) * MSM_W'(MS_RECIP);
	assign ms_qd   = ms_prod[MS_SHIFT +: MS_DIG_W];
	assign ms_rd   = ms_p - MSP_W'(ms_qd) * MSP_W'(US_PER_MS);

	assign tst_re = (cmd == CMD_TSTATE_RD_IN) || (cmd == CMD_TSTATE_RD_T);
	assign tst_ra = (cmd == CMD_TSTATE_RD_IN) ? in_tile : t_q;
	assign tst_we = ((cmd == CMD_STORE_WR) && in_q.last_frame) || (cmd == CMD_TSTATE_WB);
	assign tst_wa = (cmd == CMD_TSTATE_WB) ? t_q : in_tile;
	always_comb begin
		if (cmd == CMD_TSTATE_WB) begin
			tst_wd = '{cnt: n_q, cur: cur_q, el: el_q};
		end else begin
			tst_wd = '{cnt: CNT_W'(in_q.frame_slot) + CNT_W'(1), cur: '0, el: '0};
		end
	end

	assign st_ra  = (cmd == CMD_RES_RD) ? st_addr(in_tile, tst.cur) : st_addr(t_q, cur_q);
	assign st_wa  = st_addr(in_tile, SLOT_W'(in_q.frame_slot));
	assign cur_nx = ((CNT_W'(cur_q) + CNT_W'(1)) == n_q) ? '0 : cur_q + SLOT_W'(1);

	always_comb begin
		stat.act         = in_q.action;
		stat.load_bad    = load_bad;
		stat.started     = started_q;
		stat.div_busy    = (dcnt_q != '0) || (mcnt_q != '0);
		stat.div_q_zero  = (msq_q == 32'd0);
		stat.tile_n_zero = (tst.cnt == '0);
		stat.walk_stop   = (dur == 32'd0) || (el_q < dur);
		stat.walk_full   = ((steps_q + CNT_W'(1)) == n_q);
		stat.pass        = pass_q;
		stat.last_tile   = (t_q == TILE_W'(TILES - 1));
		stat.res_hit     = in_range && (tst.cnt != '0);
		stat.out_free    = out_free;
	end

	always_ff @(posedge clk) begin
		if (tst_we) tst_mem[tst_wa] <= tst_wd;
		if (tst_re) tst_rd_q <= tst_mem[tst_ra];
		if (cmd == CMD_STORE_WR) st_mem[st_wa] <= {in_q.frame_tile, in_q.duration_ms};
		if ((cmd == CMD_DUR_RD) || (cmd == CMD_RES_RD)) st_rd_q <= st_mem[st_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			dcnt_q      <= '0;
			mcnt_q      <= '0;
			tv_q        <= '0;
			tv_rd_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == CMD_CLEAR) started_q <= 1'b0;
			else if (cmd == CMD_START_TIME) started_q <= 1'b1;

			if (cmd == CMD_MOD_START) dcnt_q <= DCNT_W'(DIV_STEPS);
			else if (dcnt_q != '0) dcnt_q <= dcnt_q - DCNT_W'(1);

			if (cmd == CMD_DIFF) mcnt_q <= MCNT_W'(MS_DIGITS);
			else if (mcnt_q != '0) mcnt_q <= mcnt_q - MCNT_W'(1);

			if (cmd == CMD_CLEAR) tv_q <= '0;
			else if (tst_we) tv_q[tst_wa] <= 1'b1;
			if (tst_re) tv_rd_q <= tv_q[tst_ra];

			if ((cmd == CMD_EMIT_LOAD) || (cmd == CMD_EMIT_SELF) || (cmd == CMD_EMIT_STORE)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_CAPTURE) in_q <= in_word;
		if ((cmd == CMD_START_TIME) || (cmd == CMD_DIFF)) last_us_q <= in_q.now_us;

		if (cmd == CMD_DIFF) begin
			msd_q <= diff[63] ? 64'd0 : diff;
			msr_q <= '0;
		end else if (mcnt_q != '0) begin
			msd_q <= msd_q << MS_DIG_W;
			msr_q <= ms_rd[MSR_W-1:0];
			msq_q <= {msq_q[31-MS_DIG_W:0], ms_qd};
		end

		if (cmd == CMD_MOD_START) begin
			dvd_q <= {32'd0, el_q};
			rem_q <= '0;
			dvs_q <= total_q;
		end else if (dcnt_q != '0) begin
			rem_q <= ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
			dvd_q <= {dvd_q[62:0], ge};
		end

		unique case (cmd)
			CMD_DMS_LATCH: begin
				dms_q <= msq_q;
				t_q   <= '0;
			end
			CMD_TILE_NEXT: t_q <= t_q + TILE_W'(1);
			CMD_TILE_LOAD: begin
				n_q     <= tst.cnt;
				cur_q   <= tst.cur;
				el_q    <= tst.el + dms_q;
				steps_q <= '0;
				total_q <= '0;
				pass_q  <= 1'b0;
			end
			CMD_WALK_STEP: begin
				el_q    <= el_q - dur;
				total_q <= total_q + TOT_W'(dur);
				cur_q   <= cur_nx;
				steps_q <= steps_q + CNT_W'(1);
			end
			CMD_MOD_DONE: begin
				el_q    <= rem_q[31:0];
				steps_q <= '0;
				pass_q  <= 1'b1;
			end
			CMD_EMIT_LOAD: begin
				out_status_q <= load_bad;
				out_tile_q   <= 32'd0;
			end
			CMD_EMIT_SELF: begin
				out_status_q <= 1'b0;
				out_tile_q   <= in_q.tile_id;
			end
			CMD_EMIT_STORE: begin
				out_status_q <= 1'b0;
				out_tile_q   <= st_rd_q[63:32];
			end
			default: ;
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.resolved_tile = out_tile_q;

endmodule

@@ design/tile_animation_frame_timer_top.sv @@
// channel | dir | handshake     | word
// req     | in  | valid / ready | action, tile_id, frame_slot, frame_tile, duration_ms,
//         |     |               | last_frame, now_us
// rsp     | out | valid / ready | status, resolved_tile
//
// One word at a time. A tick after the first turns the time step into ms (four
// 16-bit digits by reciprocal multiply), then visits each tile: one with no frames
// is skipped, else its frames are checked in turn, and the modulo unit runs when a
// whole loop is passed; the walk is bound by the frame store read port.
// Reset empties all tiles at once. A stalled rsp holds only the last result.
module tile_animation_frame_timer_top (
	input logic       clk,
	input logic       arst_n,
	tafr_in_if.sink   req,
	tafr_out_if.source rsp
);
	import tafr_pkg::*;

	in_word_t in_word;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	always_comb begin
		in_word.action      = action_t'(req.action);
		in_word.tile_id     = req.tile_id;
		in_word.frame_slot  = req.frame_slot;
		in_word.frame_tile  = req.frame_tile;
		in_word.duration_ms = req.duration_ms;
		in_word.last_frame  = req.last_frame;
		in_word.now_us      = req.now_us;
	end

	tafr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tafr_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_word (in_word),
		.cmd     (cmd),
		.stat    (stat),
		.rsp     (rsp)
	);

endmodule

@@ design/tafr_checker.sv @@
module tafr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_status,
	input logic [31:0] rsp_resolved_tile
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("accepted a word while busy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_resolved_tile == 32'd0)
		else $error("rejected load carries a tile");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_resolved_tile))
		else $error("rsp word changed while stalled");

endmodule

bind tile_animation_frame_timer_top tafr_checker u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_resolved_tile (rsp.resolved_tile)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import tafr_pkg::*;

	typedef struct packed {
		logic        status;
		logic [31:0] resolved_tile;
	} rsp_word_t;

	typedef struct {
		in_word_t  word;
		bit        typed;
		rsp_word_t typed_rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;

	tafr_in_if  req_if ();
	tafr_out_if rsp_if ();

	tile_animation_frame_timer_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// frame timer mirror
	logic [31:0] shown_tile [TILES*MAX_FRAMES];
	logic [31:0] frame_len  [TILES*MAX_FRAMES];
	int unsigned loop_len   [TILES];
	int unsigned cur_frame  [TILES];
	logic [31:0] ms_elapsed [TILES];
	logic [63:0] prev_us;
	bit          clock_seen;

	// stimulus bookkeeping
	bit [MAX_FRAMES-1:0] slots_written [TILES];
	int unsigned         next_slot     [TILES];
	logic [63:0]         time_base;

	rsp_word_t rsp_due[$];
	int        errors;
	int        phase;
	bit        hold_off_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAIL tile_animation_frame_timer_top");
		$finish;
	end

	function automatic void wipe_timer();
		for (int i = 0; i < TILES*MAX_FRAMES; i++) begin
			shown_tile[i] = '0;
			frame_len[i]  = '0;
		end
		for (int t = 0; t < TILES; t++) begin
			loop_len[t]      = 0;
			cur_frame[t]     = 0;
			ms_elapsed[t]    = '0;
			slots_written[t] = '0;
			next_slot[t]     = 0;
		end
		prev_us    = '0;
		clock_seen = 1'b0;
	endfunction

	function automatic bit walk_loop(int t, int unsigned n, inout logic [63:0] el);
		logic [31:0] d;
		for (int unsigned s = 0; s < n; s++) begin
			d = frame_len[t*MAX_FRAMES + cur_frame[t]];
			if (d == 0 || el < {32'd0, d})
				return 1'b0;
			el -= {32'd0, d};
			cur_frame[t] = (cur_frame[t] + 1) % n;
		end
		return 1'b1;
	endfunction

	function automatic void advance_frames(int t, logic [31:0] dms);
		int unsigned n;
		logic [63:0] el;
		logic [63:0] loop_ms;
		logic [31:0] sum32;
		n = loop_len[t];
		if (n == 0)
			return;
		cur_frame[t] %= n;
		sum32 = ms_elapsed[t] + dms;
		el = {32'd0, sum32};
		if (walk_loop(t, n, el)) begin
			loop_ms = '0;
			for (int k = 0; k < n; k++)
				loop_ms += {32'd0, frame_len[t*MAX_FRAMES + k]};
			el %= loop_ms;
			void'(walk_loop(t, n, el));
		end
		ms_elapsed[t] = el[31:0];
	endfunction

	function automatic bit apply_word(in_word_t w, output rsp_word_t r);
		logic [63:0] diff;
		logic [63:0] whole_ms;
		int unsigned idx;
		r = '0;
		case (w.action)
			ACT_LOAD: begin
				if (w.tile_id >= TILES || w.frame_slot >= MAX_FRAMES) begin
					r.status = 1'b1;
					return 1'b1;
				end
				idx = w.tile_id*MAX_FRAMES + w.frame_slot;
				shown_tile[idx] = w.frame_tile;
				frame_len[idx]  = w.duration_ms;
				if (w.last_frame) begin
					loop_len[w.tile_id]   = w.frame_slot + 1;
					cur_frame[w.tile_id]  = 0;
					ms_elapsed[w.tile_id] = '0;
				end
				return 1'b1;
			end
			ACT_TICK: begin
				if (!clock_seen) begin
					clock_seen = 1'b1;
					prev_us = w.now_us;
					return 1'b0;
				end
				diff = w.now_us - prev_us;
				prev_us = w.now_us;
				if (diff[63])
					diff = '0;
				whole_ms = diff / US_PER_MS;
				if (whole_ms[31:0] != 0)
					for (int t = 0; t < TILES; t++)
						advance_frames(t, whole_ms[31:0]);
				return 1'b0;
			end
			ACT_RESOLVE: begin
				r.resolved_tile = w.tile_id;
				if (w.tile_id < TILES && loop_len[w.tile_id] != 0)
					r.resolved_tile = shown_tile[w.tile_id*MAX_FRAMES +
						(cur_frame[w.tile_id] % loop_len[w.tile_id])];
				return 1'b1;
			end
			default: begin
				wipe_timer();
				return 1'b0;
			end
		endcase
	endfunction

	function automatic in_word_t mk_word(action_t a, logic [31:0] tile, logic [3:0] slot,
			logic [31:0] ftile, logic [31:0] dur, logic last, logic [63:0] now);
		in_word_t w;
		w.action      = a;
		w.tile_id     = tile;
		w.frame_slot  = slot;
		w.frame_tile  = ftile;
		w.duration_ms = dur;
		w.last_frame  = last;
		w.now_us      = now;
		return w;
	endfunction

	function automatic logic [31:0] pick_duration();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 8)
			return 32'd0;
		if (p < 13)
			return $urandom;
		if (p < 16)
			return 32'hFFFF_FFFF;
		return $urandom_range(1, 60);
	endfunction

	function automatic in_word_t random_word();
		in_word_t            w;
		int unsigned         p;
		int unsigned         t;
		int unsigned         s;
		logic                last;
		bit [MAX_FRAMES-1:0] need;
		p = $urandom_range(0, 99);
		w = mk_word(action_t'($urandom_range(0, 3)), $urandom, 4'($urandom), $urandom,
			$urandom, 1'($urandom), {$urandom, $urandom});
		if (p < 50) begin
			w.action = ACT_LOAD;
			if ($urandom_range(0, 19) == 0) begin
				w.tile_id    = $urandom | 32'h100;
				w.last_frame = 1'($urandom);
				return w;
			end
			t = ($urandom_range(0, 9) == 0) ? $urandom_range(8, TILES-1) : $urandom_range(0, 7);
			if ($urandom_range(0, 9) == 0) begin
				s = $urandom_range(0, MAX_FRAMES-1);
				last = 1'b0;
			end else begin
				s = next_slot[t];
				last = (s == MAX_FRAMES-1) || ($urandom_range(0, 3) == 0);
			end
			slots_written[t][s] = 1'b1;
			need = (MAX_FRAMES'(1) << (s + 1)) - MAX_FRAMES'(1);
			if (last && ((slots_written[t] & need) == need))
				next_slot[t] = 0;
			else begin
				last = 1'b0;
				next_slot[t] = (s + 1) % MAX_FRAMES;
			end
			w.tile_id     = t;
			w.frame_slot  = 4'(s);
			w.duration_ms = pick_duration();
			w.last_frame  = last;
		end else if (p < 65) begin
			w.action = ACT_TICK;
			case ($urandom_range(0, 19))
				0: w.now_us = {$urandom, $urandom};
				1: w.now_us = time_base - $urandom_range(0, 50000);
				2: w.now_us = time_base + {$urandom_range(0, 15), $urandom};
				default: w.now_us = time_base + $urandom_range(0, 120000);
			endcase
			time_base = w.now_us;
		end else if (p < 98) begin
			w.action = ACT_RESOLVE;
			if ($urandom_range(0, 4) != 0)
				w.tile_id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TILES-1) :
					$urandom_range(0, 7);
		end else begin
			w.action = ACT_CLEAR;
		end
		return w;
	endfunction

	function automatic void note_accept(in_word_t w, bit typed, rsp_word_t typed_rsp);
		rsp_word_t r;
		if (w.action == ACT_CLEAR)
			for (int t = 0; t < TILES; t++) begin
				slots_written[t] = '0;
				next_slot[t] = 0;
			end
		if (apply_word(w, r))
			rsp_due.insert(rsp_due.size(), typed ? typed_rsp : r);
	endfunction

	task automatic send_word(in_word_t w, bit typed, rsp_word_t typed_rsp);
		int idle_pct;
		idle_pct = (phase == 0) ? 8 : (phase == 1) ? 73 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.action      <= w.action;
		req_if.tile_id     <= w.tile_id;
		req_if.frame_slot  <= w.frame_slot;
		req_if.frame_tile  <= w.frame_tile;
		req_if.duration_ms <= w.duration_ms;
		req_if.last_frame  <= w.last_frame;
		req_if.now_us      <= w.now_us;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		note_accept(w, typed, typed_rsp);
	endtask

	initial begin
		int        recv_idle;
		int        hold_left;
		rsp_word_t exp;
		rsp_if.ready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_if.valid && rsp_if.ready) begin
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t: expected no word actual status=%0d tile=%h", $time,
						rsp_if.status, rsp_if.resolved_tile);
				end else begin
					exp = rsp_due.pop_front();
					if (rsp_if.status !== exp.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time,
							exp.status, rsp_if.status);
					end
					if (rsp_if.resolved_tile !== exp.resolved_tile) begin
						errors++;
						$display("%0t: resolved_tile expected %h actual %h", $time,
							exp.resolved_tile, rsp_if.resolved_tile);
					end
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 3000;
			end
			recv_idle = (phase == 0) ? 73 : (phase == 1) ? 8 : 0;
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else
				rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		rsp_word_t none;
		int        wait_cycles;
		errors = 0;
		phase = 0;
		hold_off_req = 1'b0;
		time_base = '0;
		none = '0;
		wipe_timer();
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_LOAD;
		req_if.tile_id = '0;
		req_if.frame_slot = '0;
		req_if.frame_tile = '0;
		req_if.duration_ms = '0;
		req_if.last_frame = 1'b0;
		req_if.now_us = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{mk_word(ACT_RESOLVE, 32'd0, 4'd0, '0, '0, 1'b0, '0), 1'b1, '{1'b0, 32'd0}},
			'{mk_word(ACT_RESOLVE, 32'hFFFF_FFFF, 4'hF, '1, '1, 1'b1, '1), 1'b1,
				'{1'b0, 32'hFFFF_FFFF}},
			'{mk_word(ACT_LOAD, 32'd256, 4'd0, '0, '0, 1'b1, '0), 1'b1, '{1'b1, 32'd0}},
			'{mk_word(ACT_LOAD, 32'hFFFF_FFFF, 4'hF, '1, '1, 1'b1, '1), 1'b1,
				'{1'b1, 32'd0}},
			'{mk_word(ACT_TICK, '0, '0, '0, '0, 1'b0, 64'd1000), 1'b0, none},
			'{mk_word(ACT_LOAD, 32'd0, 4'd0, 32'hFFFF_FFFF, 32'd5, 1'b0, '0), 1'b1,
				'{1'b0, 32'd0}},
			'{mk_word(ACT_LOAD, 32'd0, 4'd1, 32'h1234_5678, 32'd0, 1'b1, '0), 1'b1,
				'{1'b0, 32'd0}},
			'{mk_word(ACT_RESOLVE, 32'd0, '0, '0, '0, 1'b0, '0), 1'b1,
				'{1'b0, 32'hFFFF_FFFF}},
			'{mk_word(ACT_TICK, '0, '0, '0, '0, 1'b0, 64'd8999), 1'b0, none},
			'{mk_word(ACT_RESOLVE, 32'd0, '0, '0, '0, 1'b0, '0), 1'b1,
				'{1'b0, 32'h1234_5678}},
			'{mk_word(ACT_LOAD, 32'd255, 4'd0, 32'hA5A5_A5A5, 32'd3, 1'b0, '0), 1'b0, none},
			'{mk_word(ACT_LOAD, 32'd255, 4'd1, 32'h5A5A_5A5A, 32'd4, 1'b1, '0), 1'b0, none},
			'{mk_word(ACT_TICK, '0, '0, '0, '0, 1'b0, 64'd1000), 1'b0, none},
			'{mk_word(ACT_TICK, '0, '0, '0, '0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF), 1'b0, none},
			'{mk_word(ACT_RESOLVE, 32'd255, '0, '0, '0, 1'b0, '0), 1'b0, none},
			'{mk_word(ACT_TICK, '0, '0, '0, '0, 1'b0, 64'h8000_0000_0000_0000), 1'b0, none},
			'{mk_word(ACT_TICK, '0, '0, '0, '0, 1'b0, 64'h8000_0000_0000_3A98), 1'b0, none},
			'{mk_word(ACT_RESOLVE, 32'd255, '0, '0, '0, 1'b0, '0), 1'b0, none},
			'{mk_word(ACT_RESOLVE, 32'd256, '0, '0, '0, 1'b0, '0), 1'b1, '{1'b0, 32'd256}},
			'{mk_word(ACT_CLEAR, '0, '0, '0, '0, 1'b0, '0), 1'b0, none},
			'{mk_word(ACT_RESOLVE, 32'd255, '0, '0, '0, 1'b0, '0), 1'b1, '{1'b0, 32'd255}},
			'{mk_word(ACT_TICK, '0, '0, '0, '0, 1'b0, 64'd0), 1'b0, none}
		};
		foreach (rows[i]) begin
			row = rows[i];
			send_word(row.word, row.typed, row.typed_rsp);
		end
		time_base = '0;

		for (int i = 0; i < 560; i++) begin
			if (i == 190)
				phase = 1;
			if (i == 380) begin
				phase = 2;
				hold_off_req = 1'b1;
			end
			send_word(random_word(), 1'b0, none);
		end
		req_if.valid <= 1'b0;

		wait_cycles = 0;
		while (rsp_due.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (2000) @(posedge clk);
		if (errors == 0 && rsp_due.size() == 0)
			$display("PASS tile_animation_frame_timer_top");
		else
			$display("FAIL tile_animation_frame_timer_top");
		$finish;
	end

endmodule
